FILE: rtl/core/tqwrd_pkg.sv
// ----------------------------------------------------------------------------
// tqwrd_pkg
// Shared types and constants for the two-queue weighted random dispatcher.
// ----------------------------------------------------------------------------
package tqwrd_pkg;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned PID_W      = 8;
  localparam int unsigned ENTRY_W    = PID_W + 1;  // {ready bit, pid}
  localparam int unsigned SHARE_W    = 9;
  localparam int unsigned SEED_W     = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SHARE_W-1:0] SHARE_RESET  = 9'd205;
  localparam logic [SEED_W-1:0]  SEED_DEFAULT = 16'hACE1;
  localparam logic [SEED_W-1:0]  LFSR_TAPS    = 16'hB400;

  // register index, taken from paddr[2]
  localparam logic REG_HIGH_SHARE  = 1'b0;
  localparam logic REG_RANDOM_SEED = 1'b1;

  typedef enum logic [1:0] {
    EXIT_READY    = 2'd0,
    EXIT_BLOCKED  = 2'd1,
    EXIT_FINISHED = 2'd2,
    EXIT_INVALID  = 2'd3
  } exit_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch the incoming item
    logic push;    // file the leaving process
    logic pick;    // choose a queue, start the read
    logic load;    // move the result into the output register
  } tqwrd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // output register full and not being taken
  } tqwrd_sts_t;

  // one step of the Galois LFSR
  function automatic logic [SEED_W-1:0] tqwrd_lfsr_next(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] sh;
    sh = s >> 1;
    return s[0] ? (sh ^ LFSR_TAPS) : sh;
  endfunction

endpackage

FILE: rtl/core/tqwrd_ram.sv
// ----------------------------------------------------------------------------
// tqwrd_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module tqwrd_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tqwrd_ctrl.sv
// ----------------------------------------------------------------------------
// tqwrd_ctrl
// Sequencer: accept, push, pick/read, deliver.
// ----------------------------------------------------------------------------
module tqwrd_ctrl
  import tqwrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  tqwrd_sts_t sts,
  output tqwrd_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PICK,
    ST_READ
  } state_t;

  state_t state_r;
  logic   in_tready_r;

  always_comb begin
    cmd.accept = in_tvalid && in_tready_r;
    cmd.push   = (state_r == ST_PUSH);
    cmd.pick   = (state_r == ST_PICK);
    cmd.load   = (state_r == ST_READ) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            state_r     <= ST_PUSH;
            in_tready_r <= 1'b0;
          end
        end
        ST_PUSH: begin
          state_r <= ST_PICK;
        end
        ST_PICK: begin
          state_r <= ST_READ;
        end
        ST_READ: begin
          if (!sts.out_busy) begin
            state_r     <= ST_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_tready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_tready = in_tready_r;

endmodule

FILE: rtl/core/tqwrd_dp.sv
// ----------------------------------------------------------------------------
// tqwrd_dp
// Datapath: two FIFOs in RAM, counters, LFSR, queue pick and output register.
// ----------------------------------------------------------------------------
module tqwrd_dp
  import tqwrd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tqwrd_cmd_t            cmd,
  output tqwrd_sts_t            sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [SHARE_W-1:0]    high_share,
  input  logic                  seed_load,
  input  logic [SEED_W-1:0]     seed_value,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  // latched item
  logic              has_r;
  logic [PID_W-1:0]  pid_r;
  exit_state_t       st_r;
  logic              tag_r;

  logic [CW-1:0]     hcnt_r, lcnt_r;
  logic [PW-1:0]     hhead_r, htail_r, lhead_r, ltail_r;
  logic [SEED_W-1:0] lfsr_r, lfsr_nxt;

  logic ret_r, ovf_r, bad_r, dv_r, pickh_r;

  logic              out_valid_r;
  logic              out_dv_r, out_tag_r, out_ret_r, out_ovf_r, out_bad_r;
  logic [PID_W-1:0]  out_pid_r;

  logic push_req, push_low, h_full, l_full, push_ok;
  logic h_we, l_we, h_re, l_re, any, pick_high;
  logic [PW-1:0]      h_addr, l_addr;
  logic [ENTRY_W-1:0] wdata, h_rdata, l_rdata, entry;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    push_req  = has_r && (st_r == EXIT_READY || st_r == EXIT_BLOCKED);
    push_low  = (st_r == EXIT_READY) && tag_r;
    h_full    = (hcnt_r == FULL_CNT);
    l_full    = (lcnt_r == FULL_CNT);
    push_ok   = push_req && !(push_low ? l_full : h_full);
    h_we      = cmd.push && push_ok && !push_low;
    l_we      = cmd.push && push_ok && push_low;
    wdata     = {(st_r == EXIT_READY), pid_r};

    any       = (hcnt_r != '0) || (lcnt_r != '0);
    lfsr_nxt  = tqwrd_lfsr_next(lfsr_r);
    // low byte below the share picks high first; an empty pick falls over
    pick_high = ({1'b0, lfsr_nxt[7:0]} < high_share) ? (hcnt_r != '0) : (lcnt_r == '0);
    h_re      = cmd.pick && any && pick_high;
    l_re      = cmd.pick && any && !pick_high;

    h_addr    = cmd.push ? htail_r : hhead_r;
    l_addr    = cmd.push ? ltail_r : lhead_r;
    entry     = pickh_r ? h_rdata : l_rdata;
  end

  tqwrd_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_high_ram (
    .clk   (clk),
    .we    (h_we),
    .re    (h_re),
    .addr  (h_addr),
    .wdata (wdata),
    .rdata (h_rdata)
  );

  tqwrd_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_low_ram (
    .clk   (clk),
    .we    (l_we),
    .re    (l_re),
    .addr  (l_addr),
    .wdata (wdata),
    .rdata (l_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      has_r <= in_tdata[0];
      pid_r <= in_tdata[8:1];
      st_r  <= exit_state_t'(in_tdata[10:9]);
      tag_r <= in_tdata[11];
    end
    if (cmd.push) begin
      ret_r <= has_r && (st_r == EXIT_FINISHED);
      bad_r <= has_r && (st_r == EXIT_INVALID);
      ovf_r <= push_req && !push_ok;
    end
    if (cmd.pick) begin
      dv_r    <= any;
      pickh_r <= pick_high;
    end
    if (cmd.load) begin
      out_dv_r  <= dv_r;
      out_pid_r <= dv_r ? entry[PID_W-1:0] : '0;
      out_tag_r <= dv_r && (entry[PID_W] || !pickh_r);
      out_ret_r <= ret_r;
      out_ovf_r <= ovf_r;
      out_bad_r <= bad_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r      <= '0;
      lcnt_r      <= '0;
      hhead_r     <= '0;
      htail_r     <= '0;
      lhead_r     <= '0;
      ltail_r     <= '0;
      lfsr_r      <= SEED_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      if (seed_load) begin
        lfsr_r <= (seed_value == '0) ? SEED_DEFAULT : seed_value;
      end else if (cmd.pick && any) begin
        lfsr_r <= lfsr_nxt;
      end
      if (h_we) begin
        htail_r <= ptr_inc(htail_r);
        hcnt_r  <= hcnt_r + 1'b1;
      end else if (h_re) begin
        hhead_r <= ptr_inc(hhead_r);
        hcnt_r  <= hcnt_r - 1'b1;
      end
      if (l_we) begin
        ltail_r <= ptr_inc(ltail_r);
        lcnt_r  <= lcnt_r + 1'b1;
      end else if (l_re) begin
        lhead_r <= ptr_inc(lhead_r);
        lcnt_r  <= lcnt_r - 1'b1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {3'b000, out_bad_r, out_ovf_r, out_ret_r, out_tag_r,
                         out_pid_r, out_dv_r};

  a_hcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= FULL_CNT && lcnt_r <= FULL_CNT)
    else $error("queue count above depth");

  a_pop_high: assert property (@(posedge clk) disable iff (!rst_n)
    h_re |=> hcnt_r == $past(hcnt_r) - 1'b1)
    else $error("high pop did not decrement count");

  a_no_dispatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_dv_r) |-> (out_pid_r == '0 && !out_tag_r))
    else $error("empty dispatch carries nonzero pid or tag");

  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !((h_we && h_re) || (l_we && l_re)))
    else $error("RAM written and read in one cycle");

endmodule

FILE: rtl/core/two_queue_weighted_random_dispatch_top.sv
// ----------------------------------------------------------------------------
// two_queue_weighted_random_dispatch_top
// Two-queue scheduler with LFSR-weighted pick between a high and a low FIFO.
// ----------------------------------------------------------------------------
// Each input item is one scheduling event. If a process is leaving, a ready
// one rejoins the FIFO named by its queue tag, a blocked one joins the high
// FIFO, a finished one is flagged retired, and an invalid exit state is
// flagged bad. Then, if either FIFO holds anything, one entry is dispatched:
// the LFSR steps once and its low byte below high_share picks the high FIFO
// first; an empty choice falls over to the other FIFO. A push into a full
// FIFO is dropped and flagged. Exactly one result item comes out per input
// item. Each item passes through push, pick with RAM read, and load before its
// result stands in the output register, and the next item is accepted only
// after that load, so the block takes no new item while one is in progress.
// This order follows from each FIFO living in a single-port RAM with
// registered read: the push write and the head read cannot share a cycle,
// and the read data is registered. in_tready stays high while a result
// waits in the output register; a stalled output only holds the block in its
// last step. The FIFO RAMs need no clearing; counts and pointers reset to 0.
// random_seed writes reload the LFSR at once (a seed of 0 loads 0xACE1).
// ----------------------------------------------------------------------------
module two_queue_weighted_random_dispatch_top
  import tqwrd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32   // entries per FIFO, 2..256
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // input: [0] has_leaving, [8:1] leaving_pid, [10:9] exit_state,
  //        [11] queue_tag, [15:12] zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,

  // result: [0] dispatch_valid, [8:1] dispatch_pid, [9] dispatch_tag,
  //         [10] retired_valid, [11] overflow, [12] bad_state, [15:13] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,

  // config: 0x0 high_share (9b), 0x4 random_seed (16b)
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [SHARE_W-1:0] high_share_r;
  logic [SEED_W-1:0]  random_seed_r;
  logic               cfg_wr;
  logic               seed_load;

  tqwrd_cmd_t cmd;
  tqwrd_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign seed_load  = cfg_wr && (cfg_paddr[2] == REG_RANDOM_SEED);

  // register file; only paddr[2] is decoded, so every address reaches one of the two registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_share_r  <= SHARE_RESET;
      random_seed_r <= SEED_DEFAULT;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_HIGH_SHARE:  high_share_r  <= cfg_pwdata[SHARE_W-1:0];
        REG_RANDOM_SEED: random_seed_r <= cfg_pwdata[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_HIGH_SHARE:  cfg_prdata = {{(CFG_DATA_W-SHARE_W){1'b0}}, high_share_r};
      REG_RANDOM_SEED: cfg_prdata = {{(CFG_DATA_W-SEED_W){1'b0}}, random_seed_r};
      default:         cfg_prdata = '0;
    endcase
  end

  tqwrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tqwrd_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .high_share (high_share_r),
    .seed_load  (seed_load),
    .seed_value (cfg_pwdata[SEED_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
